// ===== hw/rtl/tup_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and character classification for the text to u64 parser.
// No dependencies; imported by the front end, back end, top level, checkers and bench.
package tup_pkg;

  localparam int unsigned DEF_OFFSET_BITS = 16;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam logic [5:0]  DEF_BASE        = 6'd10;
  localparam logic [5:0]  MAX_RADIX       = 6'd36;
  localparam logic [5:0]  DIGIT_NONE      = 6'd63;
  localparam logic [63:0] ALL_ONES        = '1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_UZ    = 8'h5a;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_LZ    = 8'h7a;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEAD,
    PH_SIGNED,
    PH_ZERO,
    PH_XSEEN,
    PH_DIGITS
  } phase_t;

  typedef enum logic [1:0] {
    DS_NONE,
    DS_SOME,
    DS_OVER
  } dstat_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_RANGE,
    ST_INVALID
  } status_t;

  // Classified character as it travels from front to back
  typedef struct packed {
    logic [5:0] digit;   // 0..35, DIGIT_NONE when not alphanumeric
    logic       blank;
    logic       sign;
    logic       minus;
    logic       xchar;
    logic       hex;
    logic       starts;
    logic [5:0] base;    // number_base at the time of the transfer
  } cls_t;

  function automatic logic [5:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = {2'b00, DIGIT_NONE};
    if (c >= CH_0 && c <= CH_9) d = c - CH_0;
    else if (c >= CH_UA && c <= CH_UZ) d = c - (CH_UA - 8'd10);
    else if (c >= CH_LA && c <= CH_LZ) d = c - (CH_LA - 8'd10);
    return d[5:0];
  endfunction

  function automatic cls_t classify(input logic [7:0] c, input logic st,
                                    input logic [5:0] base);
    cls_t r;
    r.digit  = digit_of(c);
    r.blank  = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    r.sign   = (c == CH_PLUS) || (c == CH_MINUS);
    r.minus  = (c == CH_MINUS);
    r.xchar  = (c == CH_LX) || (c == CH_UX);
    r.hex    = (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UF)
            || (c >= CH_LA && c <= CH_LF);
    r.starts = st;
    r.base   = base;
    return r;
  endfunction

endpackage

// ===== hw/rtl/tup_char_if.sv =====
`timescale 1ns / 1ps
// Character channel: one raw byte per transfer plus a start-of-string flag.
// No dependencies.
interface tup_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       starts_string;

  modport source (output valid, char_byte, starts_string, input ready);
  modport sink   (input valid, char_byte, starts_string, output ready);
endinterface

// ===== hw/rtl/tup_result_if.sv =====
`timescale 1ns / 1ps
// Result channel: converted value, status code and end offset.
// No dependencies; offset width follows OFFSET_BITS.
interface tup_result_if #(parameter int unsigned OFFSET_BITS = 16);
  logic                   valid;
  logic                   ready;
  logic [63:0]            value;
  logic [1:0]             status;
  logic [OFFSET_BITS-1:0] end_offset;

  modport source (output valid, value, status, end_offset, input ready);
  modport sink   (input valid, value, status, end_offset, output ready);
endinterface

// ===== hw/rtl/tup_front.sv =====
`timescale 1ns / 1ps
// Front end: base register, character classification and offset counter.
// Depends on tup_pkg and tup_char_if.
module tup_front import tup_pkg::*; #(
  parameter int unsigned OFFSET_BITS = DEF_OFFSET_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [5:0]             cfg_wdata,
  tup_char_if.sink               chars,
  output logic                   push_valid,
  input  logic                   push_ready,
  output cls_t                   push_cls,
  output logic [OFFSET_BITS-1:0] push_pos
);

  logic [5:0]             number_base;
  logic [OFFSET_BITS-1:0] char_position;
  logic [OFFSET_BITS-1:0] char_position_next;
  logic                   xfer;

  assign chars.ready = push_ready;
  assign push_valid  = chars.valid;
  assign xfer        = chars.valid && push_ready;

  assign push_pos = chars.starts_string ? '0 : char_position;
  assign push_cls = classify(chars.char_byte, chars.starts_string, number_base);

  // offset saturates at all ones
  assign char_position_next = (push_pos == '1) ? push_pos : push_pos + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base   <= DEF_BASE;
      char_position <= '0;
    end else begin
      if (cfg_we) number_base <= cfg_wdata;
      if (xfer) char_position <= char_position_next;
    end
  end

endmodule

// ===== hw/rtl/tup_fifo.sv =====
`timescale 1ns / 1ps
// Small register queue between the front and back ends.
// No dependencies; DEPTH must be a power of two, at least 2.
module tup_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ===== hw/rtl/tup_back.sv =====
`timescale 1ns / 1ps
// Back end: parse state machine, base-N multiply-accumulate and result register.
// Depends on tup_pkg and tup_result_if.
module tup_back import tup_pkg::*; #(
  parameter int unsigned OFFSET_BITS = DEF_OFFSET_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  cls_t                   item_cls,
  input  logic [OFFSET_BITS-1:0] item_pos,
  tup_result_if.source           results
);

  phase_t                 phase;
  phase_t                 phase_next;
  logic [63:0]            accumulator;
  logic [63:0]            accumulator_next;
  logic                   minus_seen;
  logic                   minus_seen_next;
  logic [5:0]             active_base;
  logic [5:0]             active_base_next;
  dstat_t                 digit_status;
  dstat_t                 digit_status_next;
  logic [OFFSET_BITS-1:0] last_pos;
  logic [OFFSET_BITS-1:0] last_pos_next;

  logic                   out_valid;
  logic [63:0]            out_value;
  status_t                out_status;
  logic [OFFSET_BITS-1:0] out_offset;

  logic                   xfer;
  logic                   active;
  phase_t                 eff_phase;
  logic [5:0]             eff_base;
  logic                   is_zero;
  logic                   first;
  logic                   first_zero;

  logic                   do_digit;
  logic [5:0]             td_base;
  logic [63:0]            td_acc;
  dstat_t                 td_ds;
  logic                   stop;
  logic [70:0]            prod;

  logic                   emit;
  logic [63:0]            emit_value;
  status_t                emit_status;
  logic [OFFSET_BITS-1:0] emit_offset;

  assign item_ready = !out_valid || results.ready;
  assign xfer       = item_valid && item_ready;
  assign active     = xfer && (item_cls.starts || phase != PH_IDLE);

  // a start marker restarts the parse at this character
  assign eff_phase  = item_cls.starts ? PH_LEAD : phase;
  assign eff_base   = item_cls.starts ? item_cls.base : active_base;
  assign is_zero    = (item_cls.digit == 6'd0);
  assign first      = (eff_phase == PH_SIGNED)
                   || (eff_phase == PH_LEAD && !item_cls.blank && !item_cls.sign);
  assign first_zero = (eff_base == 6'd0 || eff_base == 6'd16) && is_zero;

  assign prod = 71'(td_acc) * 71'(td_base) + 71'(item_cls.digit);

  // datapath and result
  always_comb begin
    accumulator_next  = item_cls.starts ? 64'd0 : accumulator;
    minus_seen_next   = item_cls.starts ? 1'b0 : minus_seen;
    active_base_next  = eff_base;
    digit_status_next = item_cls.starts ? DS_NONE : digit_status;
    last_pos_next     = item_cls.starts ? '0 : last_pos;
    do_digit          = 1'b0;
    td_base           = eff_base;
    td_acc            = accumulator_next;
    td_ds             = digit_status_next;
    stop              = 1'b0;
    emit              = 1'b0;
    emit_value        = 64'd0;
    emit_status       = ST_OK;
    emit_offset       = '0;

    if (first) begin
      if (!first_zero) begin
        td_base  = (eff_base == 6'd0) ? DEF_BASE : eff_base;
        do_digit = 1'b1;
      end
    end else begin
      case (eff_phase)
        PH_LEAD: begin
          if (item_cls.sign) minus_seen_next = item_cls.minus;
        end
        PH_ZERO: begin
          if (item_cls.xchar) begin
            last_pos_next = item_pos;
          end else begin
            td_base  = (eff_base == 6'd0) ? 6'd8 : eff_base;
            td_acc   = 64'd0;
            td_ds    = DS_SOME;
            do_digit = 1'b1;
          end
        end
        PH_XSEEN: begin
          if (item_cls.hex) begin
            td_base  = 6'd16;
            td_acc   = 64'd0;
            td_ds    = DS_NONE;
            do_digit = 1'b1;
          end else begin
            // dangling prefix: the lone zero was the number
            emit        = 1'b1;
            emit_offset = last_pos;
          end
        end
        PH_DIGITS: do_digit = 1'b1;
        default: ;
      endcase
    end

    if (do_digit) begin
      active_base_next  = td_base;
      accumulator_next  = td_acc;
      digit_status_next = td_ds;
      stop = (td_base < 6'd2) || (td_base > MAX_RADIX) || (item_cls.digit >= td_base);
      if (stop) begin
        emit = 1'b1;
        case (td_ds)
          DS_OVER: begin
            emit_value  = ALL_ONES;
            emit_status = ST_RANGE;
            emit_offset = item_pos;
          end
          DS_SOME: begin
            emit_value  = minus_seen_next ? (64'd0 - td_acc) : td_acc;
            emit_offset = item_pos;
          end
          default: emit_status = ST_INVALID;
        endcase
      end else if (td_ds != DS_OVER) begin
        // anything above bit 63 means the value no longer fits
        if (prod[70:64] != 7'd0) begin
          digit_status_next = DS_OVER;
        end else begin
          accumulator_next  = prod[63:0];
          digit_status_next = DS_SOME;
        end
      end
    end
  end

  // next phase
  always_comb begin
    phase_next = phase;
    if (active) begin
      if (first) begin
        phase_next = first_zero ? PH_ZERO : PH_DIGITS;
      end else begin
        case (eff_phase)
          PH_LEAD:   phase_next = item_cls.sign ? PH_SIGNED : PH_LEAD;
          PH_ZERO:   phase_next = item_cls.xchar ? PH_XSEEN : PH_DIGITS;
          PH_XSEEN:  phase_next = PH_DIGITS;
          PH_DIGITS: phase_next = PH_DIGITS;
          default:   phase_next = PH_IDLE;
        endcase
      end
      if (emit) phase_next = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      accumulator  <= 64'd0;
      minus_seen   <= 1'b0;
      active_base  <= 6'd0;
      digit_status <= DS_NONE;
      last_pos     <= '0;
      out_valid    <= 1'b0;
    end else begin
      phase <= phase_next;
      if (active) begin
        accumulator  <= accumulator_next;
        minus_seen   <= minus_seen_next;
        active_base  <= active_base_next;
        digit_status <= digit_status_next;
        last_pos     <= last_pos_next;
      end
      if (active && emit) out_valid <= 1'b1;
      else if (results.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (active && emit) begin
      out_value  <= emit_value;
      out_status <= emit_status;
      out_offset <= emit_offset;
    end
  end

  assign results.valid      = out_valid;
  assign results.value      = out_value;
  assign results.status     = out_status;
  assign results.end_offset = out_offset;

endmodule

// ===== hw/rtl/text_to_u64_parser.sv =====
`timescale 1ns / 1ps
// Streaming string to unsigned 64-bit converter, top level.
// Depends on tup_pkg, tup_char_if, tup_result_if, tup_front, tup_fifo, tup_back.
//
// Usage:
//   chars   : one byte per transfer; starts_string marks the first byte of a string.
//             Feed the terminating byte (e.g. NUL) like any other: the first
//             non-digit ends the number and produces one result.
//   results : value, status (ok / range / invalid) and end_offset, at most one per string.
//   cfg_we / cfg_wdata : number_base (reset 10, 0 = detect from prefix); sampled
//             at the start of each string.
// Throughput: one character per cycle unless a held result stalls the back end; the
//   64x6 multiply-accumulate of the back end sets the pace, the front only classifies.
// Result path: the character that ends the number goes into a queue slot, and the
//   result register presents the result once the back end has taken it.
// Reset: rst (synchronous) empties the queue, drops any result and returns the
//   parser to idle; bytes without starts_string are then ignored.
// Stall: while results.ready is low the result register holds; the two-entry
//   queue keeps taking characters until it fills, then chars.ready drops.
module text_to_u64_parser import tup_pkg::*; #(
  parameter int unsigned OFFSET_BITS = DEF_OFFSET_BITS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [5:0]   cfg_wdata,
  tup_char_if.sink     chars,
  tup_result_if.source results
);

  localparam int unsigned ITEM_W = $bits(cls_t) + OFFSET_BITS;

  logic                   push_valid;
  logic                   push_ready;
  cls_t                   push_cls;
  logic [OFFSET_BITS-1:0] push_pos;
  logic                   item_valid;
  logic                   item_ready;
  logic [ITEM_W-1:0]      item_data;
  cls_t                   item_cls;
  logic [OFFSET_BITS-1:0] item_pos;

  tup_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .chars      (chars),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cls   (push_cls),
    .push_pos   (push_pos)
  );

  tup_fifo #(.WIDTH(ITEM_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  ({push_cls, push_pos}),
    .rd_valid (item_valid),
    .rd_ready (item_ready),
    .rd_data  (item_data)
  );

  assign item_cls = item_data[ITEM_W-1:OFFSET_BITS];
  assign item_pos = item_data[OFFSET_BITS-1:0];

  tup_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item_cls   (item_cls),
    .item_pos   (item_pos),
    .results    (results)
  );

endmodule

// ===== hw/rtl/tup_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the text to u64 parser, bound to the top level.
// Depends on tup_pkg and text_to_u64_parser.
module tup_checker import tup_pkg::*; #(
  parameter int unsigned OFFSET_BITS = DEF_OFFSET_BITS
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [63:0]            out_value,
  input logic [1:0]             out_status,
  input logic [OFFSET_BITS-1:0] out_offset
);

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ST_INVALID |-> out_value == 64'd0 && out_offset == '0)
    else $error("invalid result carries nonzero value or offset");

  a_range_ones: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ST_RANGE |-> out_value == ALL_ONES)
    else $error("range result is not all ones");

endmodule

bind text_to_u64_parser tup_checker #(.OFFSET_BITS(OFFSET_BITS)) u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .out_value  (results.value),
  .out_status (results.status),
  .out_offset (results.end_offset)
);

// ===== tb/tup_conv_check.sv =====
`timescale 1ns / 1ps
// Result checker for text_to_u64_parser: tracks the base register, predicts each result
// from the character transfers and compares it with the result channel.
// Depends on tup_pkg, tup_char_if and tup_result_if.
module tup_conv_check import tup_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,
  tup_char_if         chars,
  tup_result_if       results,
  output int unsigned errors,
  output int unsigned pending
);

  localparam int unsigned       OB        = DEF_OFFSET_BITS;
  localparam logic [OB-1:0]     POS_MAX   = '1;
  localparam logic [5:0]        RADIX_OCT = 6'd8;
  localparam logic [5:0]        RADIX_DEC = 6'd10;
  localparam logic [5:0]        RADIX_HEX = 6'd16;

  typedef struct packed {
    logic [63:0]   value;
    status_t       status;
    logic [OB-1:0] end_offset;
  } conv_t;

  conv_t         conv_q[$];
  conv_t         next_conv;
  logic [5:0]    base_reg;
  phase_t        phase;
  logic [63:0]   acc;
  logic          neg;
  logic [5:0]    radix;
  dstat_t        dstat;
  logic [OB-1:0] cur_pos;
  logic [OB-1:0] x_pos;

  function automatic logic [5:0] char_digit(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return 6'(c - CH_0);
    if (c >= CH_UA && c <= CH_UZ) return 6'(c - CH_UA + 8'd10);
    if (c >= CH_LA && c <= CH_LZ) return 6'(c - CH_LA + 8'd10);
    return DIGIT_NONE;
  endfunction

  function automatic bit is_blank_char(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_hex(input logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF);
  endfunction

  function automatic bit radix_ok(input logic [5:0] r);
    return r >= 6'd2 && r <= MAX_RADIX;
  endfunction

  function automatic bit close_number(input logic [63:0] v, input status_t st,
                                      input logic [OB-1:0] off);
    next_conv.value      = v;
    next_conv.status     = st;
    next_conv.end_offset = off;
    phase = PH_IDLE;
    return 1'b1;
  endfunction

  function automatic bit accumulate(input logic [7:0] c, input logic [OB-1:0] pos);
    logic [5:0]  d;
    logic [63:0] cut;
    logic [63:0] lim;
    d = char_digit(c);
    if (!radix_ok(radix) || d >= radix) begin
      if (dstat == DS_OVER) return close_number(ALL_ONES, ST_RANGE, pos);
      if (dstat == DS_SOME) return close_number(neg ? -acc : acc, ST_OK, pos);
      return close_number('0, ST_INVALID, '0);
    end
    // once overflowed, the rest of the digits are only consumed
    if (dstat != DS_OVER) begin
      cut = ALL_ONES / radix;
      lim = ALL_ONES % radix;
      if (acc > cut || (acc == cut && d > lim)) begin
        dstat = DS_OVER;
      end else begin
        acc   = acc * radix + d;
        dstat = DS_SOME;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit begin_number(input logic [7:0] c, input logic [OB-1:0] pos);
    if ((radix == 6'd0 || radix == RADIX_HEX) && c == CH_0) begin
      phase = PH_ZERO;
      return 1'b0;
    end
    if (radix == 6'd0) radix = RADIX_DEC;
    if (!radix_ok(radix)) return close_number('0, ST_INVALID, '0);
    phase = PH_DIGITS;
    return accumulate(c, pos);
  endfunction

  function automatic bit parse_char(input logic [7:0] c, input logic st);
    logic [OB-1:0] pos;
    if (st) begin
      phase = PH_LEAD;
      acc   = '0;
      neg   = 1'b0;
      radix = base_reg;
      dstat = DS_NONE;
      x_pos = '0;
      pos   = '0;
    end else begin
      if (phase == PH_IDLE) return 1'b0;
      pos = cur_pos;
    end
    cur_pos = (pos < POS_MAX) ? pos + 1'b1 : POS_MAX;
    case (phase)
      PH_LEAD: begin
        if (is_blank_char(c)) return 1'b0;
        if (c == CH_PLUS || c == CH_MINUS) begin
          neg   = (c == CH_MINUS);
          phase = PH_SIGNED;
          return 1'b0;
        end
        return begin_number(c, pos);
      end
      PH_SIGNED: return begin_number(c, pos);
      PH_ZERO: begin
        if (c == CH_LX || c == CH_UX) begin
          x_pos = pos;
          phase = PH_XSEEN;
          return 1'b0;
        end
        if (radix == 6'd0) radix = RADIX_OCT;
        acc   = '0;
        dstat = DS_SOME;
        phase = PH_DIGITS;
        return accumulate(c, pos);
      end
      PH_XSEEN: begin
        if (is_hex(c)) begin
          radix = RADIX_HEX;
          acc   = '0;
          dstat = DS_NONE;
          phase = PH_DIGITS;
          return accumulate(c, pos);
        end
        // bare 0x: the zero alone was the number
        return close_number('0, ST_OK, x_pos);
      end
      PH_DIGITS: return accumulate(c, pos);
      default: begin
        phase = PH_IDLE;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin : watch
    conv_t want;
    if (rst) begin
      base_reg = DEF_BASE;
      phase    = PH_IDLE;
      acc      = '0;
      neg      = 1'b0;
      radix    = '0;
      dstat    = DS_NONE;
      cur_pos  = '0;
      x_pos    = '0;
      conv_q.delete();
      errors   = 0;
      pending  <= 0;
    end else begin
      if (chars.valid && chars.ready) begin
        if (parse_char(chars.char_byte, chars.starts_string)) conv_q.push_back(next_conv);
      end
      if (results.valid && results.ready) begin
        if (conv_q.size() == 0) begin
          report_mismatch("unexpected result value", results.value, '0);
        end else begin
          want = conv_q.pop_front();
          if (results.value !== want.value)
            report_mismatch("value", results.value, want.value);
          if (results.status !== want.status)
            report_mismatch("status", 64'(results.status), 64'(want.status));
          if (results.end_offset !== want.end_offset)
            report_mismatch("end_offset", 64'(results.end_offset), 64'(want.end_offset));
        end
      end
      // base is sampled at the string start, so a write lands after this edge's transfer
      if (cfg_we) base_reg = cfg_wdata;
      pending <= conv_q.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Top of the text_to_u64_parser bench: clock, reset, character and base stimulus,
// result back-pressure, idle watchdog and verdict. Depends on tup_pkg, the channel
// interfaces, text_to_u64_parser and tup_conv_check.
module tb;
  import tup_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned RANDOM_CHARS = 1600;
  localparam int unsigned PHASE_CHARS  = 170;
  localparam int unsigned LONG_ZEROS   = 250;
  localparam logic [5:0]  RADIX_HEX    = 6'd16;
  localparam logic [5:0]  RADIX_OCT    = 6'd8;
  localparam logic [5:0]  RADIX_DEC    = 6'd10;
  localparam logic [7:0]  CH_NUL       = 8'h00;
  localparam logic [7:0]  CH_BANG      = 8'h21;
  localparam logic [5:0]  BASE_SWEEP [9] = '{6'd10, 6'd16, 6'd0, 6'd36, 6'd2, 6'd8,
                                             6'd1, 6'd37, 6'd63};
  localparam logic [5:0]  BASE_COMMON [6] = '{6'd0, 6'd2, 6'd8, 6'd10, 6'd16, 6'd36};

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [5:0]  cfg_wdata;
  logic        rsp_ready = 1'b0;
  bit          steady = 1'b0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sent_chars = 0;
  int unsigned errors;
  int unsigned pending;

  tup_char_if chars ();
  tup_result_if #(.OFFSET_BITS(DEF_OFFSET_BITS)) results ();

  assign results.ready = rsp_ready;

  text_to_u64_parser #(.OFFSET_BITS(DEF_OFFSET_BITS)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .chars     (chars),
    .results   (results)
  );

  tup_conv_check conv_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .chars     (chars),
    .results   (results),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // mostly short gaps, a few long ones; none at all in steady stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      rsp_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      rsp_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst || (chars.valid && chars.ready) || (results.valid && results.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_char(input logic [7:0] c, input logic st);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      chars.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    chars.valid         <= 1'b1;
    chars.char_byte     <= c;
    chars.starts_string <= st;
    do @(posedge clk); while (!chars.ready);
    sent_chars++;
  endtask

  task automatic send_text(input string s, input logic [7:0] term);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == 0);
    send_char(term, s.len() == 0);
  endtask

  task automatic drain();
    chars.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_base(input logic [5:0] b);
    drain();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [7:0] digit_char(input int unsigned v);
    if (v < 10) return CH_0 + 8'(v);
    if ($urandom_range(0, 1) != 0) return CH_UA + 8'(v - 10);
    return CH_LA + 8'(v - 10);
  endfunction

  function automatic logic [7:0] random_blank();
    if ($urandom_range(0, 1) != 0) return CH_SPACE;
    return CH_TAB + 8'($urandom_range(0, 4));
  endfunction

  task automatic send_random_string(input logic [5:0] base);
    logic [7:0]  text[$];
    int unsigned r;
    int unsigned n;
    logic [5:0]  radix;
    bit          nonzero_lead;
    nonzero_lead = 1'b0;
    radix        = base;
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 4)) text.push_back(random_blank());
    r = $urandom_range(0, 3);
    if (r == 0) text.push_back(CH_PLUS);
    else if (r == 1) text.push_back(CH_MINUS);
    if (base == 6'd0) begin
      r = $urandom_range(0, 2);
      if (r == 0) begin
        text.push_back(CH_0);
        text.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
        radix = RADIX_HEX;
      end else if (r == 1) begin
        text.push_back(CH_0);
        radix = RADIX_OCT;
      end else begin
        radix        = RADIX_DEC;
        nonzero_lead = 1'b1;
      end
    end else if (base == RADIX_HEX && $urandom_range(0, 2) == 0) begin
      text.push_back(CH_0);
      text.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
    end
    // invalid bases still get alphanumeric content
    if (radix < 6'd2 || radix > MAX_RADIX) radix = MAX_RADIX;
    r = $urandom_range(0, 99);
    if (r < 8) n = 0;
    else if (r < 70) n = $urandom_range(1, 6);
    else if (r < 90) n = $urandom_range(7, 20);
    else n = $urandom_range(21, 70);
    for (int i = 0; i < n; i++)
      text.push_back(digit_char((i == 0 && nonzero_lead) ? $urandom_range(1, 9)
                                                         : $urandom_range(0, radix - 1)));
    r = $urandom_range(0, 9);
    if (r < 5) text.push_back(CH_NUL);
    else if (r < 8) text.push_back(8'($urandom));
    else if (r == 8) text.push_back(CH_SPACE);
    // otherwise left open: the next start discards it
    foreach (text[i]) send_char(text[i], i == 0);
  endtask

  initial begin
    int unsigned goal;
    int unsigned phase_end;
    int unsigned r;
    logic [5:0]  b;
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    chars.valid         <= 1'b0;
    chars.char_byte     <= '0;
    chars.starts_string <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // decimal at the reset base
    send_text("  +12345", CH_NUL);
    send_text("\011\012\013\014\015-42", CH_SPACE);
    send_text("18446744073709551615", CH_NUL);
    send_text("18446744073709551616", CH_NUL);
    send_text("-1", CH_NUL);
    send_text("-99999999999999999999", CH_NUL);
    send_text("abc", CH_NUL);
    send_text("", CH_NUL);
    send_char(CH_0 + 8'd5, 1'b0);            // outside any string, dropped
    send_text("12", CH_0 + 8'd3);            // left open, then restarted
    send_text("45", 8'hff);
    send_text("+-7", CH_NUL);

    // long run of leading zeros, back to back
    steady = 1'b1;
    send_char(CH_0, 1'b1);
    repeat (LONG_ZEROS) send_char(CH_0, 1'b0);
    send_char(CH_0 + 8'd7, 1'b0);
    send_char(CH_NUL, 1'b0);
    steady = 1'b0;

    set_base(RADIX_HEX);
    send_text("0x1F", CH_LA + 8'd6);
    send_text("0X", CH_LA + 8'd6);
    send_text("  -0xff", CH_NUL);
    send_text("DEADBEEFcafe1234", CH_NUL);
    send_text("fffffffffffffffff", CH_NUL);
    set_base(6'd0);
    send_text("0x10", CH_NUL);
    send_text("017", CH_NUL);
    send_text("019", CH_NUL);
    send_text("0", CH_NUL);
    send_text("0x", CH_LZ);
    set_base(MAX_RADIX);
    send_text("zZ", CH_BANG);
    send_text("zzzzzzzzzzzzzz", CH_NUL);
    set_base(6'd2);
    send_text("-1011", CH_0 + 8'd2);
    set_base(6'd1);
    send_text("5", CH_NUL);
    send_text("  +", CH_LX);
    set_base(6'd37);
    send_text("12", CH_NUL);
    set_base(6'd63);
    send_text("12", CH_NUL);
    set_base(RADIX_OCT);
    send_text("0x12", CH_NUL);

    goal = sent_chars + RANDOM_CHARS;
    for (int ph = 0; sent_chars < goal; ph++) begin
      if (ph < 9) b = BASE_SWEEP[ph];
      else if ($urandom_range(0, 4) != 0) b = BASE_COMMON[$urandom_range(0, 5)];
      else b = 6'($urandom_range(0, 63));
      set_base(b);
      steady    = (ph % 4 == 3);
      phase_end = sent_chars + PHASE_CHARS;
      while (sent_chars < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 82) begin
          send_random_string(b);
        end else if (r < 94) begin
          repeat ($urandom_range(1, 8)) send_char(8'($urandom), $urandom_range(0, 5) == 0);
        end else begin
          repeat ($urandom_range(1, 3)) send_char(8'($urandom), 1'b0);
        end
      end
      steady = 1'b0;
    end

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
